// ===== sv/wfo_pkg.sv =====
// Shared constants, codes and types of the wavetable FM oscillator.
`timescale 1ns / 1ps

package wfo_pkg;

  // Table geometry
  localparam int SINE_INDEX_BITS = 12;
  localparam int WAVE_INDEX_BITS = 10;
  localparam int NUM_BANDS       = 11;

  localparam int SINE_LEN  = 1 << SINE_INDEX_BITS;
  localparam int WAVE_LEN  = 1 << WAVE_INDEX_BITS;
  localparam int MEM_DEPTH = SINE_LEN + 3 * NUM_BANDS * WAVE_LEN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ROW_W     = $clog2(3 * NUM_BANDS);

  // Phase split: fraction widths and FM term alignment
  localparam int SINE_FRAC_W = 32 - SINE_INDEX_BITS;
  localparam int WAVE_FRAC_W = 32 - WAVE_INDEX_BITS;
  localparam int FRAC_MAX_W  = (SINE_FRAC_W > WAVE_FRAC_W) ? SINE_FRAC_W : WAVE_FRAC_W;
  localparam int FM_SH_SINE  = 29 - SINE_INDEX_BITS;
  localparam int FM_SH_WAVE  = 29 - WAVE_INDEX_BITS;
  localparam int FM_Q_LSB    = 8;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = FRAC_MAX_W + 1;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int GAIN_SH = 15;

  // Stream payload layout
  localparam int TDATA_W  = 56;
  localparam int MOD_LSB  = 0;
  localparam int KIND_LSB = 16;
  localparam int BAND_LSB = 18;
  localparam int IDX_LSB  = 22;
  localparam int WORD_LSB = 34;

  // Item kinds carried in tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Waveform codes
  localparam logic [1:0] WAVE_SINE = 2'd0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PHASE_INC  = 3'd0,
    CFG_WAVE_SEL   = 3'd1,
    CFG_BAND_SEL   = 3'd2,
    CFG_FM_DEPTH   = 3'd3,
    CFG_FM_ENABLE  = 3'd4,
    CFG_INTERP_EN  = 3'd5,
    CFG_OUT_GAIN   = 3'd6
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FM     = 9'b000000010,
    ST_LOOK   = 9'b000000100,
    ST_RDA    = 9'b000001000,
    ST_RDB    = 9'b000010000,
    ST_DIFF   = 9'b000100000,
    ST_INTERP = 9'b001000000,
    ST_SCALE  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

endpackage

// ===== sv/wavetable_fm_oscillator.sv =====
// Wavetable FM oscillator: phase accumulator, wave memory and shared-multiplier sequencer.
// Sequence: a tick steps FM, LOOK, RDA, RDB, DIFF, INTERP, SCALE, OUT; OUT waits if held.
// Throughput: no beat is taken until the last sample is loaded, as the one multiplier is
//   used three times and one read port fetches both neighbors; table writes stay in IDLE.
// Reset: rst clears the phase, the control and the config registers to their defaults
//   (interpolation on, gain 1.0); the wave memory is undefined until written.
`timescale 1ns / 1ps

module wavetable_fm_oscillator (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tdata: mod_sample[15:0], table_kind[17:16], table_band[21:18],
  //        table_index[33:22], table_word[49:34], zero[55:50]
  input  logic [wfo_pkg::TDATA_W-1:0] s_tdata,
  // tuser: op[0]
  input  logic                        s_tuser,
  // Output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // tdata: sample_out[15:0]
  output logic [15:0]                 m_tdata,
  // Configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int PROD_W = wfo_pkg::PROD_W;
  localparam int NUM_W  = wfo_pkg::NUM_W;
  localparam logic signed [PROD_W-1:0] SAT_HI    = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO    = PROD_W'(-32768);
  localparam logic signed [PROD_W-1:0] GAIN_BIAS = PROD_W'((1 << wfo_pkg::GAIN_SH) - 1);
  localparam logic signed [NUM_W-1:0] SINE_BIAS = (NUM_W'(1) << wfo_pkg::SINE_FRAC_W) - 1;
  localparam logic signed [NUM_W-1:0] WAVE_BIAS = (NUM_W'(1) << wfo_pkg::WAVE_FRAC_W) - 1;

  // Configuration registers
  logic [31:0] phase_inc;
  logic [1:0]  wave_sel;
  logic [3:0]  band_sel;
  logic [15:0] fm_depth;
  logic        fm_en;
  logic        interp_en;
  logic [15:0] out_gain;

  // Datapath state
  wfo_pkg::state_t                     state;
  logic [31:0]                         phase_acc;
  logic [31:0]                         look;
  logic signed [15:0]                  mod_sample;
  logic signed [15:0]                  a_reg;
  logic signed [15:0]                  s_reg;
  logic signed [PROD_W-1:0]            prod;
  logic                                out_valid;
  logic [15:0]                         out_data;

  // Wave memory
  logic signed [15:0]                  wave_mem [wfo_pkg::MEM_DEPTH];
  logic signed [15:0]                  rd_data;
  logic                                rd_en;
  logic [wfo_pkg::ADDR_W-1:0]          rd_addr;
  logic                                wr_en;
  logic [wfo_pkg::ADDR_W-1:0]          wr_addr;

  // Input fields
  logic [1:0]  in_kind;
  logic [3:0]  in_band;
  logic [11:0] in_idx;
  logic [15:0] in_word;
  logic        s_acc;

  // Combinational helpers
  logic                                sine;
  logic [3:0]                          band_clamp;
  logic [wfo_pkg::ROW_W-1:0]           rd_row;
  logic [wfo_pkg::ROW_W-1:0]           wr_row;
  logic [1:0]                          wr_kind_m1;
  logic [1:0]                          rd_kind_m1;
  logic                                wr_ok;
  logic [31:0]                         fm_q;
  logic [31:0]                         fm_term;
  logic [wfo_pkg::SINE_INDEX_BITS-1:0] idx_s;
  logic [wfo_pkg::WAVE_INDEX_BITS-1:0] idx_w;
  logic signed [wfo_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [wfo_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [16:0]                  diff;
  logic signed [NUM_W-1:0]             a_ext;
  logic signed [NUM_W-1:0]             prod_ext;
  logic signed [NUM_W-1:0]             num;
  logic signed [NUM_W-1:0]             num_adj;
  logic signed [NUM_W-1:0]             num_sh;
  logic signed [PROD_W-1:0]            g_adj;
  logic signed [PROD_W-1:0]            g_sh;
  logic [15:0]                         sample_next;
  logic                                out_load;

  assign in_kind = s_tdata[wfo_pkg::KIND_LSB +: 2];
  assign in_band = s_tdata[wfo_pkg::BAND_LSB +: 4];
  assign in_idx  = s_tdata[wfo_pkg::IDX_LSB +: 12];
  assign in_word = s_tdata[wfo_pkg::WORD_LSB +: 16];

  assign s_tready  = (state == wfo_pkg::ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Table write address and range check
  always_comb begin
    wr_kind_m1 = in_kind - 2'd1;
    wr_row     = wfo_pkg::ROW_W'(wr_kind_m1) * wfo_pkg::ROW_W'(wfo_pkg::NUM_BANDS)
               + wfo_pkg::ROW_W'(in_band);
    if (in_kind == wfo_pkg::WAVE_SINE) begin
      wr_ok   = (16'(in_idx) < 16'(wfo_pkg::SINE_LEN));
      wr_addr = wfo_pkg::ADDR_W'(in_idx);
    end else begin
      wr_ok   = (16'(in_idx) < 16'(wfo_pkg::WAVE_LEN))
             && (5'(in_band) < 5'(wfo_pkg::NUM_BANDS));
      wr_addr = wfo_pkg::ADDR_W'(wfo_pkg::SINE_LEN)
              + (wfo_pkg::ADDR_W'(wr_row) << wfo_pkg::WAVE_INDEX_BITS)
              + wfo_pkg::ADDR_W'(in_idx);
    end
    wr_en = s_acc && (s_tuser == wfo_pkg::OP_WRITE) && wr_ok;
  end

  // Lookup address: entry in RDA, its wrapped neighbor in RDB
  always_comb begin
    sine       = (wave_sel == wfo_pkg::WAVE_SINE);
    band_clamp = (5'(band_sel) > 5'(wfo_pkg::NUM_BANDS - 1)) ? 4'(wfo_pkg::NUM_BANDS - 1)
                                                               : band_sel;
    rd_kind_m1 = wave_sel - 2'd1;
    rd_row     = wfo_pkg::ROW_W'(rd_kind_m1) * wfo_pkg::ROW_W'(wfo_pkg::NUM_BANDS)
               + wfo_pkg::ROW_W'(band_clamp);
    idx_s = look[31 -: wfo_pkg::SINE_INDEX_BITS];
    idx_w = look[31 -: wfo_pkg::WAVE_INDEX_BITS];
    if (state == wfo_pkg::ST_RDB) begin
      idx_s = idx_s + wfo_pkg::SINE_INDEX_BITS'(1);
      idx_w = idx_w + wfo_pkg::WAVE_INDEX_BITS'(1);
    end
    if (sine) begin
      rd_addr = wfo_pkg::ADDR_W'(idx_s);
    end else begin
      rd_addr = wfo_pkg::ADDR_W'(wfo_pkg::SINE_LEN)
              + (wfo_pkg::ADDR_W'(rd_row) << wfo_pkg::WAVE_INDEX_BITS)
              + wfo_pkg::ADDR_W'(idx_w);
    end
    rd_en = (state == wfo_pkg::ST_RDA) || (state == wfo_pkg::ST_RDB);
  end

  // Wave memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[wr_addr] <= in_word;
    end
    if (rd_en) begin
      rd_data <= wave_mem[rd_addr];
    end
  end

  // FM phase offset from the registered modulator product
  always_comb begin
    fm_q = prod[wfo_pkg::FM_Q_LSB +: 32];
    if (!fm_en) begin
      fm_term = '0;
    end else if (sine) begin
      fm_term = fm_q << wfo_pkg::FM_SH_SINE;
    end else begin
      fm_term = fm_q << wfo_pkg::FM_SH_WAVE;
    end
  end

  // Shared multiplier operand select: FM depth, interpolation, gain
  always_comb begin
    diff = {rd_data[15], rd_data} - {a_reg[15], a_reg};
    case (state)
      wfo_pkg::ST_FM: begin
        mul_a = wfo_pkg::MUL_A_W'(mod_sample);
        mul_b = wfo_pkg::MUL_B_W'(fm_depth);
      end
      wfo_pkg::ST_DIFF: begin
        if (sine) begin
          mul_a = wfo_pkg::MUL_A_W'(look[wfo_pkg::SINE_FRAC_W-1:0]);
        end else begin
          mul_a = wfo_pkg::MUL_A_W'(look[wfo_pkg::WAVE_FRAC_W-1:0]);
        end
        mul_b = wfo_pkg::MUL_B_W'(diff);
      end
      default: begin
        mul_a = wfo_pkg::MUL_A_W'(s_reg);
        mul_b = wfo_pkg::MUL_B_W'(out_gain);
      end
    endcase
  end

  // Interpolation: a*2^F + frac*(b-a), truncated toward zero
  always_comb begin
    a_ext    = NUM_W'(a_reg);
    prod_ext = NUM_W'(prod);
    if (sine) begin
      num     = (a_ext <<< wfo_pkg::SINE_FRAC_W) + prod_ext;
      num_adj = num[NUM_W-1] ? (num + SINE_BIAS) : num;
      num_sh  = num_adj >>> wfo_pkg::SINE_FRAC_W;
    end else begin
      num     = (a_ext <<< wfo_pkg::WAVE_FRAC_W) + prod_ext;
      num_adj = num[NUM_W-1] ? (num + WAVE_BIAS) : num;
      num_sh  = num_adj >>> wfo_pkg::WAVE_FRAC_W;
    end
  end

  // Gain: truncate toward zero, saturate to 16 bits
  always_comb begin
    g_adj = prod[PROD_W-1] ? (prod + GAIN_BIAS) : prod;
    g_sh  = g_adj >>> wfo_pkg::GAIN_SH;
    if (g_sh > SAT_HI) begin
      sample_next = 16'h7fff;
    end else if (g_sh < SAT_LO) begin
      sample_next = 16'h8000;
    end else begin
      sample_next = g_sh[15:0];
    end
    out_load = (state == wfo_pkg::ST_OUT) && (!out_valid || m_tready);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc <= '0;
      wave_sel  <= '0;
      band_sel  <= '0;
      fm_depth  <= '0;
      fm_en     <= 1'b0;
      interp_en <= 1'b1;
      out_gain  <= 16'h8000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wfo_pkg::CFG_PHASE_INC: phase_inc <= cfg_data;
        wfo_pkg::CFG_WAVE_SEL:  wave_sel  <= cfg_data[1:0];
        wfo_pkg::CFG_BAND_SEL:  band_sel  <= cfg_data[3:0];
        wfo_pkg::CFG_FM_DEPTH:  fm_depth  <= cfg_data[15:0];
        wfo_pkg::CFG_FM_ENABLE: fm_en     <= cfg_data[0];
        wfo_pkg::CFG_INTERP_EN: interp_en <= cfg_data[0];
        wfo_pkg::CFG_OUT_GAIN:  out_gain  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wfo_pkg::ST_IDLE;
      phase_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        wfo_pkg::ST_IDLE: begin
          if (s_acc && (s_tuser == wfo_pkg::OP_TICK)) begin
            state <= wfo_pkg::ST_FM;
          end
        end
        wfo_pkg::ST_FM:     state <= wfo_pkg::ST_LOOK;
        wfo_pkg::ST_LOOK: begin
          phase_acc <= phase_acc + phase_inc;
          state     <= wfo_pkg::ST_RDA;
        end
        wfo_pkg::ST_RDA:    state <= wfo_pkg::ST_RDB;
        wfo_pkg::ST_RDB:    state <= wfo_pkg::ST_DIFF;
        wfo_pkg::ST_DIFF:   state <= wfo_pkg::ST_INTERP;
        wfo_pkg::ST_INTERP: state <= wfo_pkg::ST_SCALE;
        wfo_pkg::ST_SCALE:  state <= wfo_pkg::ST_OUT;
        wfo_pkg::ST_OUT: begin
          if (out_load) begin
            state <= wfo_pkg::ST_IDLE;
          end
        end
        default: state <= wfo_pkg::ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      mod_sample <= s_tdata[wfo_pkg::MOD_LSB +: 16];
    end
    if ((state == wfo_pkg::ST_FM) || (state == wfo_pkg::ST_DIFF)
        || (state == wfo_pkg::ST_SCALE)) begin
      prod <= mul_a * mul_b;
    end
    if (state == wfo_pkg::ST_LOOK) begin
      look <= phase_acc + fm_term;
    end
    if (state == wfo_pkg::ST_RDB) begin
      a_reg <= rd_data;
    end
    if (state == wfo_pkg::ST_INTERP) begin
      s_reg <= interp_en ? num_sh[15:0] : a_reg;
    end
    if (out_load) begin
      out_data <= sample_next;
    end
  end

  // Checks
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser == wfo_pkg::OP_TICK) |=> state == wfo_pkg::ST_FM)
    else $error("tick beat did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_tuser == wfo_pkg::OP_WRITE) |=> state == wfo_pkg::ST_IDLE)
    else $error("table write left the idle state");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    state != wfo_pkg::ST_LOOK |=> $stable(phase_acc))
    else $error("phase moved outside the lookup step");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == wfo_pkg::ST_OUT))
    else $error("sample beat raised outside the output step");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> 32'(rd_addr) < 32'(wfo_pkg::MEM_DEPTH))
    else $error("wave memory read beyond its depth");

endmodule
